// ----- rtl/core/dfd_pkg.sv -----
package dfd_pkg;

  // Field and register widths.
  localparam int BYTE_W     = 8;
  localparam int LEVEL_W    = 8;
  localparam int DRIVE_W    = 10;
  localparam int PERIOD_W   = 16;
  localparam int CAP_W      = 9;
  localparam int PERMILLE_W = 10;
  localparam int CHAN_W     = 3;
  localparam int POS_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Shared multiplier and divider sizes. Every dividend stays below 2**27.
  localparam int MUL_W      = 16;
  localparam int DVD_W      = 28;
  localparam int DEN_W      = 10;
  localparam int DIV_CNT_W  = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DVD_W / 2);

  // Register reset values.
  localparam logic [BYTE_W-1:0]     SYNC_RESET = 8'd2;
  localparam logic [CAP_W-1:0]      CAP_RESET  = 9'd250;
  localparam logic [PERMILLE_W-1:0] WMP_RESET  = 10'd550;

  // Arithmetic constants.
  localparam logic [BYTE_W-1:0]  LEVEL_OFFSET  = 8'd5;
  localparam logic [DRIVE_W-1:0] LOW_LIMIT     = 10'd300;
  localparam logic [DEN_W-1:0]   PERMILLE      = 10'd1000;
  localparam logic [DEN_W-1:0]   TENTHS        = 10'd10;
  localparam logic [MUL_W-1:0]   LOW_MAIN_MULT = 16'd3;

  // Frame positions and channel numbers.
  localparam logic [POS_W-1:0]  COLOUR_COUNT = 3'd4;
  localparam logic [POS_W-1:0]  WARM_POS     = 3'd4;
  localparam logic [POS_W-1:0]  COOL_POS     = 3'd5;
  localparam logic [POS_W-1:0]  FRAME_END    = 3'd6;
  localparam logic [CHAN_W-1:0] WARM_CHAN    = 3'd4;
  localparam logic [CHAN_W-1:0] COOL_CHAN    = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_CODE,
    CFG_PERIOD_MAIN,
    CFG_PERIOD_LOW,
    CFG_WHITE_CAP,
    CFG_WHITE_MAX
  } cfg_idx_t;

  // Multiply-then-divide operations of the datapath.
  typedef enum logic [2:0] {
    OP_CAP_W,
    OP_CAP_C,
    OP_SCL_W,
    OP_SCL_C,
    OP_MAIN_HI,
    OP_MAIN_LO,
    OP_LOW
  } op_t;

  typedef enum logic [1:0] {
    DRV_COLOUR,
    DRV_WARM,
    DRV_COOL
  } drv_src_t;

  typedef enum logic [1:0] {
    PH_COLOUR,
    PH_WARM,
    PH_COOL
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAPW_MUL,
    S_CAPW_DIV,
    S_CAPC_MUL,
    S_CAPC_DIV,
    S_SCLW_MUL,
    S_SCLW_DIV,
    S_SCLC_MUL,
    S_SCLC_DIV,
    S_EM_MAIN_MUL,
    S_EM_MAIN_DIV,
    S_EM_LOW_MUL,
    S_EM_LOW_DIV,
    S_EM_OUT
  } state_t;

  typedef struct packed {
    logic is_sync;
    logic is_small;
    logic white_capped;
    logic drv_hi;
    logic div_busy;
  } dfd_sts_t;

  typedef struct packed {
    logic              start;
    op_t               op;
    logic              commit;
    logic              drv_load;
    drv_src_t          drv_src;
    logic              white_load;
    logic              warm_store;
    logic              out_load;
    logic [CHAN_W-1:0] out_chan;
    logic              out_last;
  } dfd_cmd_t;

endpackage

// ----- rtl/core/dfd_div.sv -----
module dfd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dfd_pkg::DVD_W-1:0] dividend,
  input  logic [dfd_pkg::DEN_W-1:0] divisor,
  output logic                      busy,
  output logic [dfd_pkg::DVD_W-1:0] quotient
);
  import dfd_pkg::*;

  // Restoring divider, two quotient bits per cycle. The dividend register
  // shifts left and takes the quotient bits in at the bottom.
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DVD_W-1:0] dvd_v;
    logic [DEN_W-1:0] rem_v;
    dvd_v = dvd_r;
    rem_v = rem_r;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_v, dvd_v[DVD_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_v = DEN_W'(trial - {1'b0, den_r});
        dvd_v = {dvd_v[DVD_W-2:0], 1'b1};
      end else begin
        rem_v = trial[DEN_W-1:0];
        dvd_v = {dvd_v[DVD_W-2:0], 1'b0};
      end
    end
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      den_nxt = divisor;
      cnt_nxt = DIV_STEPS;
    end else if (cnt_r != '0) begin
      dvd_nxt = dvd_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = dvd_r;

endmodule

// ----- rtl/core/dfd_dpath.sv -----
module dfd_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [dfd_pkg::BYTE_W-1:0]     in_rx_byte,
  input  dfd_pkg::dfd_cmd_t              cmd,
  output dfd_pkg::dfd_sts_t              sts,
  output logic [dfd_pkg::CHAN_W-1:0]     out_channel,
  output logic [dfd_pkg::PERIOD_W-1:0]   out_main_compare,
  output logic [dfd_pkg::PERIOD_W-1:0]   out_low_compare,
  output logic                           out_last
);
  import dfd_pkg::*;

  logic [BYTE_W-1:0]     sync_code_r;
  logic [PERIOD_W-1:0]   period_main_r;
  logic [PERIOD_W-1:0]   period_low_r;
  logic [CAP_W-1:0]      cap_r;
  logic [PERMILLE_W-1:0] wmp_r;

  logic [LEVEL_W-1:0]  warm_lvl_r;
  logic [DRIVE_W-1:0]  ws_r;
  logic [DRIVE_W-1:0]  cs_r;
  logic [CAP_W-1:0]    tot_r;
  logic [DRIVE_W-1:0]  drive_r;
  op_t                 op_r;
  logic [PERIOD_W-1:0] main_r;
  logic [PERIOD_W-1:0] low_r;

  logic [CHAN_W-1:0]   out_chan_r;
  logic [PERIOD_W-1:0] out_main_r;
  logic [PERIOD_W-1:0] out_low_r;
  logic                out_last_r;

  logic [LEVEL_W-1:0]   level_in;
  logic [CAP_W-1:0]     total_in;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [DEN_W-1:0]     den;
  logic [2*MUL_W-1:0]   product;
  logic                 div_busy;
  logic [DVD_W-1:0]     quo;
  logic [PERIOD_W-1:0]  quo_sat;

  assign level_in = in_rx_byte - LEVEL_OFFSET;
  assign total_in = CAP_W'({1'b0, warm_lvl_r} + {1'b0, level_in});

  assign sts.is_sync      = (in_rx_byte == sync_code_r);
  assign sts.is_small     = (in_rx_byte < LEVEL_OFFSET);
  assign sts.white_capped = (total_in > cap_r);
  assign sts.drv_hi       = (drive_r > LOW_LIMIT);
  assign sts.div_busy     = div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_code_r   <= SYNC_RESET;
      period_main_r <= '0;
      period_low_r  <= '0;
      cap_r         <= CAP_RESET;
      wmp_r         <= WMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_CODE:   sync_code_r   <= cfg_wdata[BYTE_W-1:0];
        CFG_PERIOD_MAIN: period_main_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_PERIOD_LOW:  period_low_r  <= cfg_wdata[PERIOD_W-1:0];
        CFG_WHITE_CAP:   cap_r         <= cfg_wdata[CAP_W-1:0];
        CFG_WHITE_MAX:   wmp_r         <= cfg_wdata[PERMILLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Operand and divisor selection of the shared multiply-divide unit.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    den   = PERMILLE;
    case (cmd.op)
      OP_CAP_W: begin
        mul_a = MUL_W'(ws_r);
        mul_b = MUL_W'(cap_r);
        den   = DEN_W'(tot_r);
      end
      OP_CAP_C: begin
        mul_a = MUL_W'(cs_r);
        mul_b = MUL_W'(cap_r);
        den   = DEN_W'(tot_r);
      end
      OP_SCL_W: begin
        mul_a = MUL_W'(ws_r);
        mul_b = MUL_W'({wmp_r, 2'b00});
      end
      OP_SCL_C: begin
        mul_a = MUL_W'(cs_r);
        mul_b = MUL_W'({wmp_r, 2'b00});
      end
      OP_MAIN_HI: begin
        mul_a = MUL_W'(drive_r);
        mul_b = period_main_r;
      end
      OP_MAIN_LO: begin
        mul_a = period_main_r;
        mul_b = LOW_MAIN_MULT;
        den   = TENTHS;
      end
      OP_LOW: begin
        mul_a = MUL_W'(LOW_LIMIT - drive_r);
        mul_b = period_low_r;
        den   = LOW_LIMIT;
      end
      default: ;
    endcase
  end

  assign product = mul_a * mul_b;

  dfd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (product[DVD_W-1:0]),
    .divisor  (den),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign quo_sat = (|quo[DVD_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}} : quo[PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_lvl_r <= '0;
    end else if (cmd.warm_store) begin
      warm_lvl_r <= level_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= cmd.op;
    end
    if (cmd.white_load) begin
      ws_r  <= DRIVE_W'(warm_lvl_r);
      cs_r  <= DRIVE_W'(level_in);
      tot_r <= total_in;
    end
    if (cmd.commit) begin
      case (op_r) inside
        OP_CAP_W, OP_SCL_W: ws_r <= quo[DRIVE_W-1:0];
        OP_CAP_C, OP_SCL_C: cs_r <= quo[DRIVE_W-1:0];
        OP_MAIN_HI: begin
          main_r <= quo_sat;
          low_r  <= '0;
        end
        OP_MAIN_LO: main_r <= quo[PERIOD_W-1:0];
        OP_LOW:     low_r  <= quo[PERIOD_W-1:0];
        default: ;
      endcase
    end
    if (cmd.drv_load) begin
      case (cmd.drv_src)
        DRV_COLOUR: drive_r <= {level_in, 2'b00};
        DRV_WARM:   drive_r <= ws_r;
        DRV_COOL:   drive_r <= cs_r;
        default:    drive_r <= ws_r;
      endcase
    end
    if (cmd.out_load) begin
      out_chan_r <= cmd.out_chan;
      out_main_r <= main_r;
      out_low_r  <= low_r;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_channel      = out_chan_r;
  assign out_main_compare = out_main_r;
  assign out_low_compare  = out_low_r;
  assign out_last         = out_last_r;

endmodule

// ----- rtl/core/dfd_ctrl.sv -----
module dfd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dfd_pkg::dfd_sts_t sts,
  output dfd_pkg::dfd_cmd_t cmd
);
  import dfd_pkg::*;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  phase_t            phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      chan_r      <= '0;
      phase_r     <= PH_COLOUR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      chan_r      <= chan_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    chan_nxt  = chan_r;
    phase_nxt = phase_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_sync) begin
            pos_nxt = '0;
          end else if (!sts.is_small) begin
            if (pos_r < COLOUR_COUNT) begin
              cmd.drv_load = 1'b1;
              cmd.drv_src  = DRV_COLOUR;
              chan_nxt     = pos_r;
              phase_nxt    = PH_COLOUR;
              state_nxt    = S_EM_MAIN_MUL;
            end else if (pos_r == WARM_POS) begin
              cmd.warm_store = 1'b1;
            end else if (pos_r == COOL_POS) begin
              cmd.white_load = 1'b1;
              state_nxt      = sts.white_capped ? S_CAPW_MUL : S_SCLW_MUL;
            end
            if (pos_r != FRAME_END) begin
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
      end
      S_CAPW_MUL: begin
        cmd.start = 1'b1;
        cmd.op    = OP_CAP_W;
        state_nxt = S_CAPW_DIV;
      end
      S_CAPW_DIV: begin
        if (!sts.div_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_CAPC_MUL;
        end
      end
      S_CAPC_MUL: begin
        cmd.start = 1'b1;
        cmd.op    = OP_CAP_C;
        state_nxt = S_CAPC_DIV;
      end
      S_CAPC_DIV: begin
        if (!sts.div_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_SCLW_MUL;
        end
      end
      S_SCLW_MUL: begin
        cmd.start = 1'b1;
        cmd.op    = OP_SCL_W;
        state_nxt = S_SCLW_DIV;
      end
      S_SCLW_DIV: begin
        if (!sts.div_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_SCLC_MUL;
        end
      end
      S_SCLC_MUL: begin
        cmd.start = 1'b1;
        cmd.op    = OP_SCL_C;
        state_nxt = S_SCLC_DIV;
      end
      S_SCLC_DIV: begin
        if (!sts.div_busy) begin
          cmd.commit   = 1'b1;
          cmd.drv_load = 1'b1;
          cmd.drv_src  = DRV_WARM;
          phase_nxt    = PH_WARM;
          state_nxt    = S_EM_MAIN_MUL;
        end
      end
      S_EM_MAIN_MUL: begin
        cmd.start = 1'b1;
        cmd.op    = sts.drv_hi ? OP_MAIN_HI : OP_MAIN_LO;
        state_nxt = S_EM_MAIN_DIV;
      end
      S_EM_MAIN_DIV: begin
        if (!sts.div_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = sts.drv_hi ? S_EM_OUT : S_EM_LOW_MUL;
        end
      end
      S_EM_LOW_MUL: begin
        cmd.start = 1'b1;
        cmd.op    = OP_LOW;
        state_nxt = S_EM_LOW_DIV;
      end
      S_EM_LOW_DIV: begin
        if (!sts.div_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_EM_OUT;
        end
      end
      S_EM_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          unique case (phase_r)
            PH_WARM: begin
              cmd.out_chan = WARM_CHAN;
              cmd.out_last = 1'b0;
              cmd.drv_load = 1'b1;
              cmd.drv_src  = DRV_COOL;
              phase_nxt    = PH_COOL;
              state_nxt    = S_EM_MAIN_MUL;
            end
            PH_COOL: begin
              cmd.out_chan = COOL_CHAN;
              cmd.out_last = 1'b1;
              state_nxt    = S_IDLE;
            end
            default: begin
              cmd.out_chan = chan_r;
              cmd.out_last = 1'b1;
              state_nxt    = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // A started division must be running in the following cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> sts.div_busy)
    else $error("divider not busy after start");

  // The frame position never runs past the end of the frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= FRAME_END)
    else $error("frame position out of range");

  // The block only takes a new byte once the divider has finished.
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.div_busy)
    else $error("ready while divider busy");

  // A result is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> (!cmd.out_load ##1 out_valid_r))
    else $error("pending result lost");

endmodule

// ----- rtl/core/dimmer_frame_decoder.sv -----
// Channel   Direction  Handshake            Payload
// --------  ---------  -------------------  ------------------------------------------------
// in        input      in_valid/in_ready    in_rx_byte
// out       output     out_valid/out_ready  out_channel, out_main_compare, out_low_compare,
//                                           out_last
// cfg       input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// Every multiply-and-divide step runs on the one shared multiplier and the
// two-bits-per-cycle divider; that divider sets the pace of the block.
// A colour byte needs one multiply-divide step (drive above 300 per mille) or two otherwise.
// Cool-white bytes add cap and scaling steps; sync, small, warm and overrun bytes use none.
// Reset is synchronous and active low; it restores the register defaults and frame position 0.
// A stalled output holds its result while the next byte is already taken and worked on.
module dimmer_frame_decoder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dfd_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dfd_pkg::CHAN_W-1:0]     out_channel,
  output logic [dfd_pkg::PERIOD_W-1:0]   out_main_compare,
  output logic [dfd_pkg::PERIOD_W-1:0]   out_low_compare,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [dfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dfd_pkg::*;

  // The controller sequences the work of one byte: it tracks the frame
  // position, decides which results a byte causes and steps the datapath
  // through its multiply-and-divide operations. The datapath holds the
  // configuration registers, the warm-white level, the shared arithmetic
  // and the output register.
  dfd_cmd_t cmd;
  dfd_sts_t sts;

  dfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // A white pair over the total cap is limited to it, then both levels are
  // scaled to the full-scale white drive, and warm is sent before cool.
  // Each drive then becomes a main and a low-range compare value.
  dfd_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_channel      (out_channel),
    .out_main_compare (out_main_compare),
    .out_low_compare  (out_low_compare),
    .out_last         (out_last)
  );

endmodule
